### rtl/point_in_polygon_test_core_defines.svh
// ----------------------------------------------------------------------------
// point_in_polygon_test_core_defines
// assertion macros for the point-in-polygon test core
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define PIPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define PIPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pipt_pkg.sv
// ----------------------------------------------------------------------------
// pipt_pkg
// shared constants and control bundle of the point-in-polygon test core
// ----------------------------------------------------------------------------
package pipt_pkg;

  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_COORD_BITS   = 16;
  localparam int CNT_BITS         = 9;
  localparam int INDEX_BITS       = 8;

  typedef struct packed {
    logic latch_pt;
    logic clear;
    logic load_prev;
    logic load_edge;
    logic mul_p;
    logic mul_q;
    logic cmp;
  } ctrl_t;

endpackage

### rtl/pipt_store.sv
// ----------------------------------------------------------------------------
// pipt_store
// vertex memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module pipt_store #(
  parameter int MAX_VERTICES = pipt_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = pipt_pkg::DEF_COORD_BITS,
  parameter int IW           = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [pipt_pkg::INDEX_BITS-1:0]     wr_index,
  input  logic [2*COORD_BITS-1:0]             wdata,
  input  logic [IW-1:0]                       rd_addr,
  output logic [2*COORD_BITS-1:0]             rdata
);
  import pipt_pkg::*;

  logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
  logic                    in_range;

  assign in_range = 32'(wr_index) < MAX_VERTICES;

  always_ff @(posedge clk) begin
    if (we && in_range) begin
      mem[IW'(wr_index)] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

endmodule

### rtl/pipt_cross.sv
// ----------------------------------------------------------------------------
// pipt_cross
// edge crossing datapath around one shared signed multiplier
// ----------------------------------------------------------------------------
module pipt_cross #(
  parameter int COORD_BITS = pipt_pkg::DEF_COORD_BITS
) (
  input  logic                         clk,
  input  pipt_pkg::ctrl_t              ctrl,
  input  logic signed [COORD_BITS-1:0] pt_x,
  input  logic signed [COORD_BITS-1:0] pt_y,
  input  logic signed [COORD_BITS-1:0] rd_x,
  input  logic signed [COORD_BITS-1:0] rd_y,
  output logic                         parity
);
  import pipt_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_BITS-1:0] tx, ty, xj, yj;
  logic signed [DW-1:0]         a, b, c, d;
  logic signed [DW-1:0]         a_next, b_next, c_next, d_next;
  logic signed [DW-1:0]         mop_a, mop_b;
  logic signed [PW-1:0]         prod, p, q;
  logic                         straddle, straddle_next, flip;

  always_comb begin
    straddle_next = (rd_y > ty) != (yj > ty);
    flip          = yj < rd_y;
    a_next        = DW'(tx) - DW'(rd_x);
    c_next        = DW'(xj) - DW'(rd_x);
    b_next        = flip ? (DW'(rd_y) - DW'(yj)) : (DW'(yj) - DW'(rd_y));
    d_next        = flip ? (DW'(rd_y) - DW'(ty)) : (DW'(ty) - DW'(rd_y));
    mop_a         = ctrl.mul_q ? c : a;
    mop_b         = ctrl.mul_q ? d : b;
    prod          = PW'(mop_a) * PW'(mop_b);
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch_pt) begin
      tx <= pt_x;
      ty <= pt_y;
    end
    if (ctrl.clear) begin
      parity <= 1'b0;
    end else if (ctrl.cmp && straddle && (p < q)) begin
      parity <= ~parity;
    end
    if (ctrl.load_prev) begin
      xj <= rd_x;
      yj <= rd_y;
    end
    if (ctrl.load_edge) begin
      straddle <= straddle_next;
      a        <= a_next;
      b        <= b_next;
      c        <= c_next;
      d        <= d_next;
      xj       <= rd_x;
      yj       <= rd_y;
    end
    if (ctrl.mul_p) begin
      p <= prod;
    end
    if (ctrl.mul_q) begin
      q <= prod;
    end
  end

endmodule

### rtl/pipt_ctrl.sv
// ----------------------------------------------------------------------------
// pipt_ctrl
// query sequencer: walks the edges and steps the shared multiplier
// ----------------------------------------------------------------------------
module pipt_ctrl #(
  parameter int MAX_VERTICES = pipt_pkg::DEF_MAX_VERTICES,
  parameter int IW           = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  parameter int NW           = ($clog2(MAX_VERTICES + 1) > pipt_pkg::CNT_BITS) ?
                               $clog2(MAX_VERTICES + 1) : pipt_pkg::CNT_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            mode,
  input  logic [NW-1:0]   cnt,
  output logic            busy,
  output logic            done,
  output logic            we,
  output logic [IW-1:0]   rd_addr,
  output pipt_pkg::ctrl_t ctrl
);
  import pipt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREV, S_EDGE, S_MULP, S_MULQ, S_CMP
  } state_t;

  state_t        state;
  logic [IW-1:0] idx;
  logic          last;
  logic          query;

  assign busy    = state != S_IDLE;
  assign query   = start && !busy && mode;
  assign we      = start && !busy && !mode;
  assign rd_addr = (state == S_IDLE) ? IW'(cnt - NW'(1)) : idx;

  always_comb begin
    ctrl           = '0;
    ctrl.latch_pt  = query;
    ctrl.clear     = query;
    ctrl.load_prev = state == S_PREV;
    ctrl.load_edge = state == S_EDGE;
    ctrl.mul_p     = state == S_MULP;
    ctrl.mul_q     = state == S_MULQ;
    ctrl.cmp       = state == S_CMP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      idx   <= '0;
      last  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (query) begin
            idx <= '0;
            if (cnt == '0) begin
              done <= 1'b1;
            end else begin
              state <= S_PREV;
            end
          end
        end
        S_PREV: begin
          state <= S_EDGE;
        end
        S_EDGE: begin
          last  <= NW'(idx) == (cnt - NW'(1));
          state <= S_MULP;
        end
        S_MULP: begin
          idx   <= idx + IW'(1);
          state <= S_MULQ;
        end
        S_MULQ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (last) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_EDGE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/point_in_polygon_test_core.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_core
// ray-crossing point-in-polygon test over a stored vertex list
//
//   channel   handshake                  payload
//   item in   start, busy                mode, vertex_index, coord_x, coord_y
//   result    done (one-cycle strobe)    inside_res
//   config    cfg_valid, cfg_ready       cfg_data (vertex_count)
//
// a vertex write leaves busy low
// a query walks one edge per stored vertex, the result strobe follows;
// each edge is stepped through the single shared multiplier
// (two products, one operand setup, one compare)
// an empty polygon answers in the cycle after the transfer
// rst is synchronous; the vertex memory is not cleared
// ----------------------------------------------------------------------------
module point_in_polygon_test_core #(
  parameter int MAX_VERTICES = pipt_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = pipt_pkg::DEF_COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            mode,
  input  logic [pipt_pkg::INDEX_BITS-1:0] vertex_index,
  input  logic signed [COORD_BITS-1:0]    coord_x,
  input  logic signed [COORD_BITS-1:0]    coord_y,
  output logic                            done,
  output logic                            inside_res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pipt_pkg::CNT_BITS-1:0]   cfg_data
);
  import pipt_pkg::*;
  `include "point_in_polygon_test_core_defines.svh"

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = ($clog2(MAX_VERTICES + 1) > CNT_BITS) ?
                      $clog2(MAX_VERTICES + 1) : CNT_BITS;

  logic [NW-1:0]           vertex_count;
  logic [NW-1:0]           cfg_ext;
  logic                    we;
  logic [IW-1:0]           rd_addr;
  logic [2*COORD_BITS-1:0] rdata;
  ctrl_t                   ctrl;
  logic                    walk_query;
  logic                    empty_query;
  logic                    write_xfer;

  assign cfg_ready = !busy;
  assign cfg_ext   = NW'(cfg_data);

  assign walk_query  = start && !busy && mode && (vertex_count != '0);
  assign empty_query = start && !busy && mode && (vertex_count == '0);
  assign write_xfer  = start && !busy && !mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= (cfg_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : cfg_ext;
    end
  end

  pipt_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .IW           (IW),
    .NW           (NW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .mode    (mode),
    .cnt     (vertex_count),
    .busy    (busy),
    .done    (done),
    .we      (we),
    .rd_addr (rd_addr),
    .ctrl    (ctrl)
  );

  pipt_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS),
    .IW           (IW)
  ) u_store (
    .clk      (clk),
    .we       (we),
    .wr_index (vertex_index),
    .wdata    ({coord_x, coord_y}),
    .rd_addr  (rd_addr),
    .rdata    (rdata)
  );

  pipt_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk    (clk),
    .ctrl   (ctrl),
    .pt_x   (coord_x),
    .pt_y   (coord_y),
    .rd_x   (rdata[2*COORD_BITS-1:COORD_BITS]),
    .rd_y   (rdata[COORD_BITS-1:0]),
    .parity (inside_res)
  );

  `PIPT_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while a query is running")
  `PIPT_ASSERT_NEXT(a_query_busy, walk_query, busy && !done, "query did not start the edge walk")
  `PIPT_ASSERT_NEXT(a_empty_done, empty_query, done && !inside_res, "empty polygon answer wrong")
  `PIPT_ASSERT_NEXT(a_write_quiet, write_xfer, !busy && !done, "vertex write started a query")

endmodule
